// ===== sv/pos_pkg.sv =====
// Package for the probe offset stepper: shared types, register indexes,
// mode flag positions, servo limits and the saturating arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package pos_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 32;
    localparam int CNT_W      = 24;
    localparam int FLAG_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd5;

    localparam int FLAG_OFFSET = 0;
    localparam int FLAG_DRIFT  = 1;
    localparam int FLAG_ZMOVE  = 2;
    localparam int FLAG_ZAUTO  = 3;

    localparam logic signed [POS_W-1:0] SAFE_LIMIT_Z = -32'sd983040000;
    localparam logic signed [POS_W-1:0] OK_LOWER_Z   = 32'sd163840000;
    localparam logic signed [POS_W-1:0] OK_UPPER_Z   = 32'sd327680000;
    localparam logic signed [POS_W-1:0] S32_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] S32_MIN      = 32'sh8000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] step_x;
        logic signed [POS_W-1:0] step_y;
        logic signed [POS_W-1:0] step_z;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic [CNT_W-1:0]        step_count;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] step_z_now;
        logic [FLAG_W-1:0]       flags;
        logic [CNT_W-1:0]        steps_left;
        logic [CNT_W-1:0]        wait_left;
    } t_state;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        if (s[POS_W] != s[POS_W-1]) begin
            return s[POS_W] ? S32_MIN : S32_MAX;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_neg(
        input logic signed [POS_W-1:0] a
    );
        if (a == S32_MIN) begin
            return S32_MAX;
        end
        return -a;
    endfunction

endpackage

// ===== sv/pos_cfg_regs.sv =====
// Configuration register file of the probe offset stepper.
// Depends on pos_pkg for the register indexes and the t_cfg type.
`timescale 1ns / 1ps

module pos_cfg_regs
    import pos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEP_X:     r_cfg.step_x     <= i_cfg_wdata;
                REG_STEP_Y:     r_cfg.step_y     <= i_cfg_wdata;
                REG_STEP_Z:     r_cfg.step_z     <= i_cfg_wdata;
                REG_TARGET_X:   r_cfg.target_x   <= i_cfg_wdata;
                REG_TARGET_Y:   r_cfg.target_y   <= i_cfg_wdata;
                REG_STEP_COUNT: r_cfg.step_count <= i_cfg_wdata[CNT_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/pos_tick.sv =====
// Next-state logic of the probe offset stepper: start loading and one tick
// of the offset, drift, Z move and Z auto-adjust modes.
// Depends on pos_pkg for types, limits and saturating helpers.
`timescale 1ns / 1ps

module pos_tick
    import pos_pkg::*;
(
    input  t_state                  i_state,
    input  t_cfg                    i_cfg,
    input  logic                    i_mode,
    input  logic [FLAG_W-1:0]       i_flags,
    input  logic signed [POS_W-1:0] i_ctl,
    output t_state                  o_state
);

    always_comb begin
        t_state s;
        s = i_state;
        if (i_mode) begin
            s.flags      = i_flags;
            s.steps_left = i_cfg.step_count;
            s.step_z_now = i_cfg.step_z;
        end else begin
            if (s.flags[FLAG_OFFSET]) begin
                if (s.steps_left != '0) begin
                    s.pos_x      = sat_add(s.pos_x, i_cfg.step_x);
                    s.pos_y      = sat_add(s.pos_y, i_cfg.step_y);
                    s.steps_left = s.steps_left - 1'b1;
                end else begin
                    s.flags = '0;
                    s.pos_x = i_cfg.target_x;
                    s.pos_y = i_cfg.target_y;
                end
            end else if (s.flags[FLAG_DRIFT]) begin
                if (s.wait_left != '0) begin
                    s.wait_left = s.wait_left - 1'b1;
                end else begin
                    s.wait_left = s.steps_left;
                    s.pos_x     = sat_add(s.pos_x, i_cfg.step_x);
                    s.pos_y     = sat_add(s.pos_y, i_cfg.step_y);
                    s.pos_z     = sat_add(s.pos_z, s.step_z_now);
                end
            end

            if (s.flags[FLAG_ZMOVE]) begin
                if (s.steps_left != '0) begin
                    if ($signed(s.step_z_now) > 0 && i_ctl < SAFE_LIMIT_Z) begin
                        s.step_z_now        = '0;
                        s.flags[FLAG_ZMOVE] = 1'b0;
                    end else begin
                        s.pos_z = sat_add(s.pos_z, s.step_z_now);
                    end
                    s.steps_left = s.steps_left - 1'b1;
                end else begin
                    s.step_z_now        = '0;
                    s.flags[FLAG_ZMOVE] = 1'b0;
                end
            end else if (s.flags[FLAG_ZAUTO]) begin
                if (s.steps_left != '0) begin
                    // point the step away from or towards the surface
                    if (i_ctl > OK_LOWER_Z) begin
                        if ($signed(s.step_z_now) <= 0) begin
                            s.step_z_now = sat_neg(s.step_z_now);
                        end
                    end else if ($signed(s.step_z_now) > 0) begin
                        s.step_z_now = -s.step_z_now;
                    end
                    if (i_ctl < OK_UPPER_Z && i_ctl > 0) begin
                        s.step_z_now        = '0;
                        s.flags[FLAG_ZAUTO] = 1'b0;
                    end else begin
                        s.pos_z = sat_add(s.pos_z, s.step_z_now);
                    end
                    s.steps_left = s.steps_left - 1'b1;
                end else begin
                    s.step_z_now        = '0;
                    s.flags[FLAG_ZAUTO] = 1'b0;
                end
            end
        end
        o_state = s;
    end

endmodule

// ===== sv/probe_offset_stepper.sv =====
// Probe offset stepper top level: input register, next-state logic and the
// state register that doubles as the result register.
// Depends on pos_pkg, pos_cfg_regs and pos_tick.
// An accepted item passes the input register, then the state register.
// Throughput: one item per cycle unless the output stalls; the tick logic,
// two saturating adds and a negation on Z, sits between those registers.
// Reset (synchronous, active low) clears position, counters, flags and config.
`timescale 1ns / 1ps

module probe_offset_stepper
    import pos_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_mode,
    input  logic [FLAG_W-1:0]       i_start_flags,
    input  logic signed [POS_W-1:0] i_z_control,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [FLAG_W-1:0]       o_active_flags
);

    t_cfg                    cfg;
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_in_valid;
    logic                    r_in_mode;
    logic [FLAG_W-1:0]       r_in_flags;
    logic signed [POS_W-1:0] r_in_ctl;
    logic                    r_out_valid;
    logic                    advance;
    logic                    in_acc;

    pos_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pos_tick u_tick (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_mode  (r_in_mode),
        .i_flags (r_in_flags),
        .i_ctl   (r_in_ctl),
        .o_state (n_state)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mode  <= i_mode;
            r_in_flags <= i_start_flags;
            r_in_ctl   <= i_z_control;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_x        = r_state.pos_x;
    assign o_pos_y        = r_state.pos_y;
    assign o_pos_z        = r_state.pos_z;
    assign o_active_flags = r_state.flags;

endmodule

// ===== sv/pos_checker.sv =====
// Port-level checker for the probe offset stepper, bound to the top level.
// Depends on pos_pkg for field widths.
`timescale 1ns / 1ps

module pos_checker
    import pos_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [POS_W-1:0] o_pos_x,
    input logic signed [POS_W-1:0] o_pos_y,
    input logic signed [POS_W-1:0] o_pos_z,
    input logic [FLAG_W-1:0]       o_active_flags
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_active_flags))
        else $error("stalled result item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output path is free");

    a_item_emerges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_out_valid |=> ##1 o_out_valid)
        else $error("accepted item did not reach the output");

endmodule

bind probe_offset_stepper pos_checker u_pos_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for probe_offset_stepper: directed and random start and tick
// items under several register settings and idling phases, checked against an in-bench model.
// Depends on pos_pkg and the probe_offset_stepper RTL.
`timescale 1ns / 1ps

module testbench;
    import pos_pkg::*;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    localparam logic [FLAG_W-1:0] F_OFFSET = FLAG_W'(1 << FLAG_OFFSET);
    localparam logic [FLAG_W-1:0] F_DRIFT  = FLAG_W'(1 << FLAG_DRIFT);
    localparam logic [FLAG_W-1:0] F_ZMOVE  = FLAG_W'(1 << FLAG_ZMOVE);
    localparam logic [FLAG_W-1:0] F_ZAUTO  = FLAG_W'(1 << FLAG_ZAUTO);
    localparam logic [FLAG_W-1:0] F_NONE   = '0;

    localparam int LONG_HOLD      = 200;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 72;
    localparam int RANDOM_PHASES  = 8;

    typedef struct packed {
        logic                    mode;
        logic [FLAG_W-1:0]       flags;
        logic signed [POS_W-1:0] ctl;
    } probe_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [FLAG_W-1:0]       flags;
    } probe_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_mode;
    logic [FLAG_W-1:0]       i_start_flags;
    logic signed [POS_W-1:0] i_z_control;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [POS_W-1:0] o_pos_z;
    logic [FLAG_W-1:0]       o_active_flags;

    probe_offset_stepper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_start_flags  (i_start_flags),
        .i_z_control    (i_z_control),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_active_flags (o_active_flags)
    );

    // model copy of the registers and the stepping state
    logic signed [POS_W-1:0] cfg_step_x   = '0;
    logic signed [POS_W-1:0] cfg_step_y   = '0;
    logic signed [POS_W-1:0] cfg_step_z   = '0;
    logic signed [POS_W-1:0] cfg_target_x = '0;
    logic signed [POS_W-1:0] cfg_target_y = '0;
    logic [CNT_W-1:0]        cfg_count    = '0;

    logic signed [POS_W-1:0] probe_x         = '0;
    logic signed [POS_W-1:0] probe_y         = '0;
    logic signed [POS_W-1:0] probe_z         = '0;
    logic signed [POS_W-1:0] live_zstep      = '0;
    logic [FLAG_W-1:0]       active_mask     = '0;
    logic [CNT_W-1:0]        remaining_steps = '0;
    logic [CNT_W-1:0]        drift_countdown = '0;

    probe_item_t   pending_items[$];
    probe_result_t expected_positions[$];
    probe_item_t   cur_item;

    int errors             = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;
    int phase_added        = 0;

    function automatic logic signed [POS_W-1:0] clamp_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(S32_MAX)) begin
            return S32_MAX;
        end
        if (s < longint'(S32_MIN)) begin
            return S32_MIN;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] flip_clamped(
        input logic signed [POS_W-1:0] a
    );
        if (a == S32_MIN) begin
            return S32_MAX;
        end
        return -a;
    endfunction

    task automatic step_probe(input probe_item_t it, output probe_result_t res);
        if (it.mode == MODE_START) begin
            active_mask     = it.flags;
            remaining_steps = cfg_count;
            live_zstep      = cfg_step_z;
        end else begin
            if (active_mask[FLAG_OFFSET]) begin
                if (remaining_steps != 0) begin
                    probe_x = clamp_add(probe_x, cfg_step_x);
                    probe_y = clamp_add(probe_y, cfg_step_y);
                    remaining_steps = remaining_steps - 1'b1;
                end else begin
                    active_mask = '0;
                    probe_x = cfg_target_x;
                    probe_y = cfg_target_y;
                end
            end else if (active_mask[FLAG_DRIFT]) begin
                if (drift_countdown != 0) begin
                    drift_countdown = drift_countdown - 1'b1;
                end else begin
                    drift_countdown = remaining_steps;
                    probe_x = clamp_add(probe_x, cfg_step_x);
                    probe_y = clamp_add(probe_y, cfg_step_y);
                    probe_z = clamp_add(probe_z, live_zstep);
                end
            end

            if (active_mask[FLAG_ZMOVE]) begin
                if (remaining_steps != 0) begin
                    if (live_zstep > 0 && it.ctl < SAFE_LIMIT_Z) begin
                        live_zstep = '0;
                        active_mask[FLAG_ZMOVE] = 1'b0;
                    end else begin
                        probe_z = clamp_add(probe_z, live_zstep);
                    end
                    remaining_steps = remaining_steps - 1'b1;
                end else begin
                    live_zstep = '0;
                    active_mask[FLAG_ZMOVE] = 1'b0;
                end
            end else if (active_mask[FLAG_ZAUTO]) begin
                if (remaining_steps != 0) begin
                    if (it.ctl > OK_LOWER_Z) begin
                        if (live_zstep <= 0) begin
                            live_zstep = flip_clamped(live_zstep);
                        end
                    end else if (live_zstep > 0) begin
                        live_zstep = -live_zstep;
                    end
                    if (it.ctl < OK_UPPER_Z && it.ctl > 0) begin
                        live_zstep = '0;
                        active_mask[FLAG_ZAUTO] = 1'b0;
                    end else begin
                        probe_z = clamp_add(probe_z, live_zstep);
                    end
                    remaining_steps = remaining_steps - 1'b1;
                end else begin
                    live_zstep = '0;
                    active_mask[FLAG_ZAUTO] = 1'b0;
                end
            end
        end
        res.pos_x = probe_x;
        res.pos_y = probe_y;
        res.pos_z = probe_z;
        res.flags = active_mask;
    endtask

    function automatic int field_mismatch(
        input string                   name,
        input logic signed [POS_W-1:0] want,
        input logic signed [POS_W-1:0] got
    );
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom();
            2: v = S32_MAX;
            3: v = -S32_MAX;
            4: v = $urandom_range(0, 10000) - 5000;
            default: v = '0;
        endcase
        if (v == S32_MIN) begin
            v = S32_MAX;
        end
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_target();
        case ($urandom_range(0, 3))
            0: return S32_MIN;
            1: return S32_MAX;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_control();
        case ($urandom_range(0, 6))
            0, 1: return $urandom();
            2: return SAFE_LIMIT_Z + $urandom_range(0, 4) - 2;
            3: return OK_LOWER_Z + $urandom_range(0, 4) - 2;
            4: return OK_UPPER_Z + $urandom_range(0, 4) - 2;
            5: return OK_LOWER_Z + $urandom_range(0, OK_UPPER_Z - OK_LOWER_Z);
            default: return $urandom_range(0, 4) - 2;
        endcase
    endfunction

    task automatic queue_item(
        input logic                    mode,
        input logic [FLAG_W-1:0]       flags,
        input logic signed [POS_W-1:0] ctl
    );
        probe_item_t it;
        it.mode  = mode;
        it.flags = flags;
        it.ctl   = ctl;
        pending_items.push_back(it);
        phase_added++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_STEP_X:     cfg_step_x   = data;
            REG_STEP_Y:     cfg_step_y   = data;
            REG_STEP_Z:     cfg_step_z   = data;
            REG_TARGET_X:   cfg_target_x = data;
            REG_TARGET_Y:   cfg_target_y = data;
            REG_STEP_COUNT: cfg_count    = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure_random(input bit longest_count);
        logic [CNT_W-1:0] count;
        if (longest_count) begin
            count = '1;
        end else begin
            count = $urandom_range(0, 9);
        end
        write_reg(REG_STEP_X, pick_step());
        write_reg(REG_STEP_Y, pick_step());
        write_reg(REG_STEP_Z, pick_step());
        write_reg(REG_TARGET_X, pick_target());
        write_reg(REG_TARGET_Y, pick_target());
        write_reg(REG_STEP_COUNT, {8'($urandom()), count});
        end_writes();
    endtask

    task automatic queue_sequences(input int n);
        int ticks;
        phase_added = 0;
        while (phase_added < n) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_item(MODE_START, 4'($urandom()), $urandom());
                ticks = ((cfg_count > 10) ? 10 : int'(cfg_count)) * 2 + $urandom_range(1, 4);
                repeat (ticks) queue_item(MODE_TICK, 4'($urandom()), pick_control());
            end else begin
                queue_item(1'($urandom()), 4'($urandom()), pick_control());
            end
        end
    endtask

    // wait out every outstanding item, then let the pipeline go quiet
    task automatic settle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_positions.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        probe_result_t res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                step_probe(cur_item, res);
                expected_positions.push_back(res);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    i_in_valid    <= 1'b1;
                    i_mode        <= cur_item.mode;
                    i_start_flags <= cur_item.flags;
                    i_z_control   <= cur_item.ctl;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        probe_result_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d flags=%h", $time,
                             o_pos_x, o_pos_y, o_pos_z, o_active_flags);
                end else begin
                    want = expected_positions.pop_front();
                    errors += field_mismatch("pos_x", want.pos_x, o_pos_x);
                    errors += field_mismatch("pos_y", want.pos_y, o_pos_y);
                    errors += field_mismatch("pos_z", want.pos_z, o_pos_z);
                    errors += field_mismatch("active_flags", POS_W'(want.flags),
                                             POS_W'(o_active_flags));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_TICK;
        i_start_flags = '0;
        i_z_control   = '0;
        i_out_stall   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_STEP_X, S32_MAX);
        write_reg(REG_STEP_Y, -S32_MAX);
        write_reg(REG_STEP_Z, S32_MAX);
        write_reg(REG_TARGET_X, S32_MIN);
        write_reg(REG_TARGET_Y, S32_MAX);
        write_reg(REG_STEP_COUNT, 32'hFF00_0002);
        end_writes();

        phase_added = 0;
        queue_item(MODE_TICK, F_NONE, S32_MAX);
        queue_item(MODE_TICK, F_NONE, S32_MIN);
        queue_item(MODE_START, F_OFFSET | F_DRIFT | F_ZMOVE | F_ZAUTO, '0);
        queue_item(MODE_TICK, '1, '0);
        queue_item(MODE_TICK, F_NONE, '0);
        queue_item(MODE_START, F_OFFSET | F_DRIFT, '1);
        repeat (3) queue_item(MODE_TICK, F_NONE, OK_LOWER_Z);
        queue_item(MODE_START, F_DRIFT, '0);
        repeat (5) queue_item(MODE_TICK, F_NONE, '0);
        queue_item(MODE_START, F_ZMOVE, '0);
        queue_item(MODE_TICK, F_NONE, SAFE_LIMIT_Z - 1);
        queue_item(MODE_START, F_ZMOVE | F_ZAUTO, '0);
        repeat (3) queue_item(MODE_TICK, F_NONE, SAFE_LIMIT_Z);
        queue_item(MODE_START, F_ZAUTO, '0);
        queue_item(MODE_TICK, F_NONE, OK_UPPER_Z);
        queue_item(MODE_TICK, F_NONE, -32'sd5);
        queue_item(MODE_TICK, F_NONE, OK_LOWER_Z + 1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
            endcase
            configure_random(p == 3);
            if (p == 2) begin
                queue_sequences(PHASE_ITEMS / 2);
                settle();
                queue_sequences(PHASE_ITEMS / 2);
            end else begin
                queue_sequences(PHASE_ITEMS);
            end
            if (p == 0) begin
                hold_requests++;
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
